FILE: hw/rtl/run_length_rank_query_defines.svh
// ----------------------------------------------------------------------------
// Run-length rank query: assertion macros
// Shared checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef RUN_LENGTH_RANK_QUERY_DEFINES_SVH
`define RUN_LENGTH_RANK_QUERY_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define RLRQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define RLRQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/rlrq_pkg.sv
// ----------------------------------------------------------------------------
// Run-length rank query package
// Widths, command codes and transaction types shared by the chain and top.
// ----------------------------------------------------------------------------
`default_nettype none

package rlrq_pkg;

  localparam int MaxRuns = 64;
  localparam int CountW  = $clog2(MaxRuns + 1);
  localparam int SymW    = 4;
  localparam int LenW    = 12;
  localparam int PosW    = 18;
  localparam int CmdW    = 2;

  localparam logic [PosW-1:0] RankMax = {PosW{1'b1}};

  localparam logic [CmdW-1:0] CmdClear  = 2'd0;
  localparam logic [CmdW-1:0] CmdAppend = 2'd1;
  localparam logic [CmdW-1:0] CmdQuery  = 2'd2;

  typedef struct packed {
    logic [CmdW-1:0] command;
    logic [SymW-1:0] run_symbol;
    logic [LenW-1:0] run_length;
    logic [SymW-1:0] query_symbol;
    logic [PosW-1:0] query_index;
  } item_t;

  typedef struct packed {
    logic [PosW-1:0] rank;
    logic            out_of_range;
  } result_t;

  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic [LenW-1:0] length;
  } run_t;

  typedef struct packed {
    logic            valid;
    logic            done;
    logic [SymW-1:0] symbol;
    logic [PosW-1:0] index;
    logic [PosW-1:0] start;
    logic [PosW-1:0] rank;
  } token_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rlrq_cell.sv
// ----------------------------------------------------------------------------
// Run-length rank query: chain cell
// Holds one run and updates the query token passing through it.
// ----------------------------------------------------------------------------
`default_nettype none

module rlrq_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            advance,
  input  wire logic            present,
  input  wire logic            we,
  input  wire rlrq_pkg::run_t  wr_run,
  input  wire rlrq_pkg::token_t tok_in,
  output rlrq_pkg::token_t     tok_out
);

  rlrq_pkg::run_t   run;
  rlrq_pkg::token_t tok_next;

  logic                          live;
  logic                          match;
  logic                          reach;
  logic [rlrq_pkg::PosW:0]       end_pos;
  logic [rlrq_pkg::PosW-1:0]     addend;
  logic [rlrq_pkg::PosW:0]       rank_sum;

  always_ff @(posedge clk) begin
    if (we) begin
      run <= wr_run;
    end
  end

  always_comb begin
    live     = tok_in.valid && !tok_in.done && present;
    match    = run.symbol == tok_in.symbol;
    end_pos  = {1'b0, tok_in.start} + (rlrq_pkg::PosW+1)'(run.length);
    reach    = end_pos >= {1'b0, tok_in.index};
    addend   = reach ? (tok_in.index - tok_in.start) : rlrq_pkg::PosW'(run.length);
    rank_sum = {1'b0, tok_in.rank} + {1'b0, addend};
    tok_next = tok_in;
    if (live) begin
      if (match) begin
        tok_next.rank = rank_sum[rlrq_pkg::PosW] ? rlrq_pkg::RankMax
                                                 : rank_sum[rlrq_pkg::PosW-1:0];
      end
      if (reach) begin
        tok_next.done = 1'b1;
      end else begin
        tok_next.start = end_pos[rlrq_pkg::PosW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (advance) begin
      tok_out <= tok_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/run_length_rank_query.sv
// Clear and append take effect at acceptance. A rank query token walks the
// 64-cell chain, one stored run per cell, and then loads the output register;
// no new item is accepted while a query is in flight. Clear and append can be
// accepted every cycle while no query is in flight. Reset: run count cleared,
// chain and output emptied.
// ----------------------------------------------------------------------------
// Run-length rank query top level
// Run store as a row of cells; a query token walks the row and sums matches.
// ----------------------------------------------------------------------------
`default_nettype none

`include "run_length_rank_query_defines.svh"

module run_length_rank_query (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire rlrq_pkg::item_t   item,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output rlrq_pkg::result_t      result
);

  logic [rlrq_pkg::CountW-1:0]  run_count;
  logic                         busy;
  logic                         accept;
  logic                         advance;
  logic                         load_result;
  logic [rlrq_pkg::MaxRuns-1:0] present;
  logic [rlrq_pkg::MaxRuns-1:0] we;
  logic [rlrq_pkg::MaxRuns-1:0] tok_live;
  rlrq_pkg::run_t               wr_run;
  rlrq_pkg::token_t             chain [rlrq_pkg::MaxRuns+1];
  rlrq_pkg::token_t             tail;

  assign item_stall  = busy;
  assign accept      = item_valid && !item_stall;
  assign tail        = chain[rlrq_pkg::MaxRuns];
  assign load_result = tail.valid && (!result_valid || !result_stall);
  assign advance     = !tail.valid || load_result;

  assign wr_run.symbol = item.run_symbol;
  assign wr_run.length = item.run_length;

  always_comb begin
    chain[0].valid  = accept && (item.command == rlrq_pkg::CmdQuery);
    chain[0].done   = 1'b0;
    chain[0].symbol = item.query_symbol;
    chain[0].index  = item.query_index;
    chain[0].start  = '0;
    chain[0].rank   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_count <= '0;
    end else if (accept) begin
      if (item.command == rlrq_pkg::CmdClear) begin
        run_count <= '0;
      end else if (item.command == rlrq_pkg::CmdAppend &&
                   run_count != rlrq_pkg::CountW'(rlrq_pkg::MaxRuns)) begin
        run_count <= run_count + rlrq_pkg::CountW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (chain[0].valid) begin
      busy <= 1'b1;
    end else if (load_result) begin
      busy <= 1'b0;
    end
  end

  for (genvar i = 0; i < rlrq_pkg::MaxRuns; i++) begin : g_cell
    assign present[i]  = rlrq_pkg::CountW'(i) < run_count;
    assign we[i]       = accept && (item.command == rlrq_pkg::CmdAppend) &&
                         (run_count == rlrq_pkg::CountW'(i));
    assign tok_live[i] = chain[i+1].valid;

    rlrq_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .present (present[i]),
      .we      (we[i]),
      .wr_run  (wr_run),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      result.rank         <= tail.rank;
      result.out_of_range <= !(tail.done || tail.index == '0);
    end
  end

  `RLRQ_ASSERT_NOW(a_single_token, 1'b1, $countones(tok_live) <= 1,
                   "more than one query in the chain")
  `RLRQ_ASSERT_NOW(a_token_busy, |tok_live, busy, "query in flight while not busy")
  `RLRQ_ASSERT_NOW(a_count_bound, 1'b1, run_count <= rlrq_pkg::CountW'(rlrq_pkg::MaxRuns),
                   "run count beyond store depth")
  `RLRQ_ASSERT_NEXT(a_result_load, tail.valid && !result_valid, result_valid && !busy,
                    "finished query not moved to output")

endmodule

`default_nettype wire

FILE: test/tb_run_length_rank_query.sv
// ----------------------------------------------------------------------------
// Run-length rank query testbench
// Fills the run store, clears it and issues rank queries from a queue, in
// bursts with gaps, against a stalling receiver. Every rank result is checked
// field by field against a store and rank calculation kept inside the bench.
// ----------------------------------------------------------------------------
module tb_run_length_rank_query;

  localparam logic [rlrq_pkg::CmdW-1:0] CmdUnused = 2'd3;
  localparam int ItemTarget = 1800;
  localparam int IdleLimit  = 3000;
  localparam int TailCycles = 100;
  localparam int IndexMax   = (1 << rlrq_pkg::PosW) - 1;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              item_valid   = 1'b0;
  logic              item_stall;
  rlrq_pkg::item_t   item         = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  rlrq_pkg::result_t result;

  run_length_rank_query uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  rlrq_pkg::item_t   pending_items[$];
  rlrq_pkg::result_t expected_ranks[$];
  rlrq_pkg::result_t oldest;

  rlrq_pkg::run_t    stored_runs[rlrq_pkg::MaxRuns];
  int unsigned       stored_count = 0;

  int unsigned                 plan_ends[$];
  logic [rlrq_pkg::SymW-1:0]   plan_syms[$];
  int                          plan_items = 0;

  int errors          = 0;
  int results_checked = 0;
  int beyond_total    = 0;
  int appends_kept    = 0;
  int appends_dropped = 0;
  int clears_seen     = 0;
  int accepted_items  = 0;
  int idle_cycles     = 0;
  int gap_left        = 0;
  int burst_left      = 1;
  int stall_cycle     = 0;

  function automatic void update_runs_and_rank(input rlrq_pkg::item_t it);
    int unsigned       start;
    int unsigned       len;
    int unsigned       acc;
    int unsigned       i;
    bit                found;
    rlrq_pkg::result_t r;
    case (it.command)
      rlrq_pkg::CmdClear: begin
        stored_count = 0;
        clears_seen++;
      end
      rlrq_pkg::CmdAppend: begin
        if (stored_count < rlrq_pkg::MaxRuns) begin
          stored_runs[stored_count].symbol = it.run_symbol;
          stored_runs[stored_count].length = it.run_length;
          stored_count++;
          appends_kept++;
        end else begin
          appends_dropped++;
        end
      end
      rlrq_pkg::CmdQuery: begin
        start = 0;
        acc   = 0;
        found = 1'b0;
        for (i = 0; i < stored_count && !found; i++) begin
          len = stored_runs[i].length;
          if (start + len >= it.query_index) begin
            if (stored_runs[i].symbol == it.query_symbol) acc += it.query_index - start;
            found = 1'b1;
          end else begin
            if (stored_runs[i].symbol == it.query_symbol) acc += len;
            start += len;
          end
        end
        if (!found && it.query_index == 0) found = 1'b1;
        if (acc > rlrq_pkg::RankMax) acc = rlrq_pkg::RankMax;
        r.rank         = acc[rlrq_pkg::PosW-1:0];
        r.out_of_range = !found;
        expected_ranks.insert(expected_ranks.size(), r);
      end
      default: ;
    endcase
  endfunction

  task automatic queue_item(input logic [rlrq_pkg::CmdW-1:0] cmd, input int unsigned sym,
                            input int unsigned val);
    rlrq_pkg::item_t it;
    logic [63:0]     noise;
    int unsigned     total;
    noise      = {$urandom, $urandom};
    it         = noise[$bits(rlrq_pkg::item_t)-1:0];
    it.command = cmd;
    total      = (plan_ends.size() != 0) ? plan_ends[$] : 0;
    case (cmd)
      rlrq_pkg::CmdClear: begin
        plan_ends.delete();
        plan_syms.delete();
        plan_items++;
      end
      rlrq_pkg::CmdAppend: begin
        it.run_symbol = sym[rlrq_pkg::SymW-1:0];
        it.run_length = val[rlrq_pkg::LenW-1:0];
        if (plan_ends.size() < rlrq_pkg::MaxRuns) begin
          plan_ends.insert(plan_ends.size(), total + val[rlrq_pkg::LenW-1:0]);
          plan_syms.insert(plan_syms.size(), sym[rlrq_pkg::SymW-1:0]);
          plan_items++;
        end
      end
      rlrq_pkg::CmdQuery: begin
        it.query_symbol = sym[rlrq_pkg::SymW-1:0];
        it.query_index  = val[rlrq_pkg::PosW-1:0];
        plan_items++;
      end
      default: ;
    endcase
    pending_items.insert(pending_items.size(), it);
  endtask

  // driver: bursts of transactions separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      gap_left   = $urandom_range(0, 20);
      burst_left = 1;
    end else begin
      if (item_valid && !item_stall) begin
        update_runs_and_rank(item);
        accepted_items++;
      end
      if (!item_valid || !item_stall) begin
        if (gap_left > 0 || pending_items.size() == 0) begin
          if (gap_left > 0) gap_left--;
          item_valid <= 1'b0;
        end else begin
          item       <= pending_items.pop_front();
          item_valid <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
          end
        end
      end
    end
  end

  // monitor: check each result, stall on a shifting pattern
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_cycle  = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_ranks.size() == 0) begin
          $error("unexpected result: rank %0d, out_of_range %0d",
                 result.rank, result.out_of_range);
          errors++;
        end else begin
          oldest = expected_ranks.pop_front();
          results_checked++;
          if (oldest.out_of_range) beyond_total++;
          if (result.rank !== oldest.rank) begin
            $error("rank: expected %0d, actual %0d", oldest.rank, result.rank);
            errors++;
          end
          if (result.out_of_range !== oldest.out_of_range) begin
            $error("out_of_range: expected %0d, actual %0d",
                   oldest.out_of_range, result.out_of_range);
            errors++;
          end
        end
      end
      stall_cycle++;
      case ((stall_cycle / 700) % 4)
        0:       result_stall <= 1'b0;
        1:       result_stall <= ($urandom_range(0, 2) == 0);
        2:       result_stall <= ((stall_cycle % 11) < 4);
        default: result_stall <= ((stall_cycle % 150) < 90);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          n;
    int          runs;
    int          queries;
    int          len_hi;
    int          item_total;
    int unsigned total;
    int unsigned idx;
    int unsigned sym;
    logic [31:0] pick;

    // empty store
    queue_item(rlrq_pkg::CmdQuery, 0, 0);
    queue_item(rlrq_pkg::CmdQuery, 15, 1);
    queue_item(rlrq_pkg::CmdQuery, 5, IndexMax);
    queue_item(CmdUnused, 3, 3);
    // longest runs around a zero-length and a unit-length run
    queue_item(rlrq_pkg::CmdAppend, 15, 4095);
    queue_item(rlrq_pkg::CmdAppend, 0, 0);
    queue_item(rlrq_pkg::CmdAppend, 0, 1);
    queue_item(rlrq_pkg::CmdAppend, 15, 4095);
    queue_item(rlrq_pkg::CmdQuery, 15, 0);
    queue_item(rlrq_pkg::CmdQuery, 15, 4095);
    queue_item(rlrq_pkg::CmdQuery, 0, 4095);
    queue_item(rlrq_pkg::CmdQuery, 0, 4096);
    queue_item(rlrq_pkg::CmdQuery, 15, 8191);
    queue_item(rlrq_pkg::CmdQuery, 15, 8192);
    queue_item(rlrq_pkg::CmdQuery, 0, IndexMax);
    queue_item(rlrq_pkg::CmdQuery, 7, 100);
    queue_item(CmdUnused, 15, 4095);
    queue_item(rlrq_pkg::CmdClear, 0, 0);
    queue_item(rlrq_pkg::CmdQuery, 15, 0);
    queue_item(rlrq_pkg::CmdQuery, 15, 5);
    queue_item(rlrq_pkg::CmdAppend, 9, 2);
    queue_item(rlrq_pkg::CmdQuery, 9, 1);
    queue_item(rlrq_pkg::CmdClear, 0, 0);

    while (plan_items < ItemTarget) begin
      if ($urandom_range(0, 9) < 8) begin
        if ($urandom_range(0, 3) != 0) queue_item(rlrq_pkg::CmdClear, $urandom, $urandom);
        runs   = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 12);
        len_hi = ($urandom_range(0, 2) == 0) ? 4095 : (($urandom_range(0, 1) == 0) ? 3 : 40);
        for (n = 0; n < runs; n++) begin
          queue_item(rlrq_pkg::CmdAppend,
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2),
                     $urandom_range(0, len_hi));
        end
        queries = $urandom_range(1, 6);
        for (n = 0; n < queries; n++) begin
          total = (plan_ends.size() != 0) ? plan_ends[$] : 0;
          case ($urandom_range(0, 6))
            0: idx = 0;
            1: idx = total;
            2: idx = total + $urandom_range(1, 3);
            3: idx = (plan_ends.size() != 0)
                     ? plan_ends[$urandom_range(0, plan_ends.size() - 1)]
                       + $urandom_range(0, 2) - 1
                     : $urandom_range(0, 3);
            4, 5: idx = $urandom_range(0, total);
            default: idx = $urandom_range(0, IndexMax);
          endcase
          sym = (plan_syms.size() != 0 && $urandom_range(0, 3) != 0)
                ? plan_syms[$urandom_range(0, plan_syms.size() - 1)]
                : $urandom_range(0, 15);
          queue_item(rlrq_pkg::CmdQuery, sym, idx);
        end
      end else begin
        // scatter loose transactions of any command
        runs = $urandom_range(1, 4);
        for (n = 0; n < runs; n++) begin
          pick = $urandom;
          queue_item(pick[rlrq_pkg::CmdW-1:0], $urandom, $urandom);
        end
      end
    end
    item_total = pending_items.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while ((accepted_items < item_total || expected_ranks.size() != 0)
           && idle_cycles < IdleLimit) @(negedge clk);

    if (idle_cycles >= IdleLimit) begin
      $display("FAILED: results differ");
    end else begin
      repeat (TailCycles) @(posedge clk);
      $display("Covered %0d transactions: %0d rank results checked, %0d beyond the total.",
               accepted_items, results_checked, beyond_total);
      $display("Runs stored %0d, dropped on a full store %0d, store clears %0d.",
               appends_kept, appends_dropped, clears_seen);
      if (errors == 0) begin
        $display("PASSED: all results match");
      end else begin
        $display("FAILED: results differ");
      end
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/rlrq_pkg.sv
hw/rtl/rlrq_cell.sv
hw/rtl/run_length_rank_query.sv
test/tb_run_length_rank_query.sv
